// ===== sv/kped_pkg.sv =====
// Shared types, codes and defaults for the key press event detector.
// No dependencies; compile first.
package kped_pkg;

    localparam int KEY_COUNT_DEF = 2;
    localparam int MASK_W        = 2;
    localparam int PIN_W         = 2;
    localparam int IDX_W         = 1;
    localparam int CNT_W         = 8;
    localparam int ST_W          = 3;
    localparam int EV_W          = 2;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 8;

    // key states
    localparam logic [ST_W-1:0] ST_RELEASED = 3'd0;
    localparam logic [ST_W-1:0] ST_BOUNCE   = 3'd1;
    localparam logic [ST_W-1:0] ST_PRESSED  = 3'd2;
    localparam logic [ST_W-1:0] ST_WAIT     = 3'd3;
    localparam logic [ST_W-1:0] ST_SECOND   = 3'd4;
    localparam logic [ST_W-1:0] ST_LONG     = 3'd5;

    // event codes
    localparam logic [EV_W-1:0] EV_NONE   = 2'd0;
    localparam logic [EV_W-1:0] EV_SHORT  = 2'd1;
    localparam logic [EV_W-1:0] EV_DOUBLE = 2'd2;
    localparam logic [EV_W-1:0] EV_LONG   = 2'd3;

    // command codes
    localparam logic CMD_SCAN = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MASK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_TICKS = 2'd3;

    // configuration defaults
    localparam logic [MASK_W-1:0] ENABLE_MASK_RST  = 2'd3;
    localparam logic [CNT_W-1:0]  LONG_TICKS_RST   = 8'd30;
    localparam logic [CNT_W-1:0]  GAP_TICKS_RST    = 8'd3;
    localparam logic [CNT_W-1:0]  SECOND_TICKS_RST = 8'd20;

    typedef struct packed {
        logic [CNT_W-1:0] long_ticks;
        logic [CNT_W-1:0] gap_ticks;
        logic [CNT_W-1:0] second_ticks;
    } kped_thr_t;

endpackage

// ===== sv/kped_cmd_if.sv =====
// Command channel: scan ticks and event reads.
// Depends on kped_pkg.
interface kped_cmd_if
    import kped_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             cmd;
    logic [PIN_W-1:0] pin_levels;
    logic [IDX_W-1:0] key_index;

    modport source (output valid, output cmd, output pin_levels, output key_index,
                    input ready);
    modport sink   (input valid, input cmd, input pin_levels, input key_index,
                    output ready);
endinterface

// ===== sv/kped_evt_if.sv =====
// Result channel: reported key events.
// Depends on kped_pkg.
interface kped_evt_if
    import kped_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [EV_W-1:0]  press_code;
    logic [IDX_W-1:0] key_echo;

    modport source (output valid, output press_code, output key_echo, input ready);
    modport sink   (input valid, input press_code, input key_echo, output ready);
endinterface

// ===== sv/key_press_event_detector.sv =====
// Key press event detector: one item per cycle while ready, scan or read.
// A read gives a registered result; a scan tick gives none.
// Results are held in an output register, backed by a one-item skid stage.
// Reset clears every key to released with zero counters and no event,
// and loads the default enable mask and thresholds.
module key_press_event_detector
    import kped_pkg::*;
#(
    parameter int KEY_COUNT = KEY_COUNT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    kped_cmd_if.sink              cmd_ch,
    kped_evt_if.source            evt_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [MASK_W-1:0] mask_reg;
    kped_thr_t         thr_reg;
    logic              accept;
    logic              scan;
    logic              push;
    logic              full;
    logic [EV_W-1:0]   latch [KEY_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg             <= ENABLE_MASK_RST;
            thr_reg.long_ticks   <= LONG_TICKS_RST;
            thr_reg.gap_ticks    <= GAP_TICKS_RST;
            thr_reg.second_ticks <= SECOND_TICKS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_ENABLE_MASK:  mask_reg             <= cfg_data[MASK_W-1:0];
                REG_LONG_TICKS:   thr_reg.long_ticks   <= cfg_data[CNT_W-1:0];
                REG_GAP_TICKS:    thr_reg.gap_ticks    <= cfg_data[CNT_W-1:0];
                REG_SECOND_TICKS: thr_reg.second_ticks <= cfg_data[CNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cmd_ch.ready = !full;
    assign accept       = cmd_ch.valid && cmd_ch.ready;
    assign scan         = accept && (cmd_ch.cmd == CMD_SCAN);
    assign push         = accept && (cmd_ch.cmd == CMD_READ);

    for (genvar k = 0; k < KEY_COUNT; k++)
    begin : g_lane
        logic en;
        logic pin;
        if (k < MASK_W)
        begin : g_scanned
            assign en  = mask_reg[k];
            assign pin = cmd_ch.pin_levels[k];
        end
        else
        begin : g_idle
            assign en  = 1'b0;
            assign pin = 1'b1;
        end

        kped_lane u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .scan_en  (scan && en),
            .pin_high (pin),
            .rd_clr   (push && (k == int'(cmd_ch.key_index))),
            .thr      (thr_reg),
            .latch    (latch[k])
        );
    end

    kped_merge #(
        .KEY_COUNT (KEY_COUNT)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .key_index (cmd_ch.key_index),
        .latch     (latch),
        .full      (full),
        .evt       (evt_ch)
    );

endmodule

// ===== sv/kped_lane.sv =====
// One key lane: six-state press machine, counters and event latch.
// Depends on kped_pkg.
module kped_lane
    import kped_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            scan_en,
    input  logic            pin_high,
    input  logic            rd_clr,
    input  kped_thr_t       thr,
    output logic [EV_W-1:0] latch
);

    logic [ST_W-1:0]  state_reg,  state_next;
    logic [ST_W-1:0]  origin_reg, origin_next;
    logic [EV_W-1:0]  event_reg,  event_next;
    logic [CNT_W-1:0] hold_reg,   hold_next;
    logic [CNT_W-1:0] gap_reg,    gap_next;
    logic [CNT_W-1:0] second_reg, second_next;
    logic [CNT_W-1:0] hold_inc, gap_inc, second_inc;

    assign hold_inc   = hold_reg + CNT_W'(1);
    assign gap_inc    = gap_reg + CNT_W'(1);
    assign second_inc = second_reg + CNT_W'(1);

    always_comb
    begin
        state_next  = state_reg;
        origin_next = origin_reg;
        event_next  = event_reg;
        hold_next   = hold_reg;
        gap_next    = gap_reg;
        second_next = second_reg;
        if (scan_en)
        begin
            unique case (state_reg)
                ST_RELEASED:
                begin
                    event_next = EV_NONE;
                    if (!pin_high)
                        state_next = ST_BOUNCE;
                end
                ST_BOUNCE:
                begin
                    if (pin_high)
                    begin
                        if (origin_reg == ST_RELEASED || origin_reg == ST_LONG)
                            state_next = ST_RELEASED;
                        else if (origin_reg == ST_PRESSED)
                        begin
                            gap_next   = '0;
                            state_next = ST_WAIT;
                        end
                        else if (origin_reg == ST_SECOND)
                        begin
                            event_next = EV_DOUBLE;
                            state_next = ST_RELEASED;
                        end
                    end
                    else
                    begin
                        if (origin_reg == ST_PRESSED || origin_reg == ST_SECOND ||
                            origin_reg == ST_LONG)
                            state_next = origin_reg;
                        else if (origin_reg == ST_RELEASED)
                        begin
                            hold_next  = '0;
                            state_next = ST_PRESSED;
                        end
                        else if (origin_reg == ST_WAIT)
                        begin
                            second_next = '0;
                            state_next  = ST_SECOND;
                        end
                    end
                end
                ST_PRESSED:
                begin
                    if (pin_high)
                        state_next = ST_BOUNCE;
                    else if (hold_inc == thr.long_ticks)
                    begin
                        hold_next  = '0;
                        event_next = EV_LONG;
                        state_next = ST_LONG;
                    end
                    else
                        hold_next = hold_inc;
                end
                ST_WAIT:
                begin
                    if (!pin_high)
                        state_next = ST_BOUNCE;
                    else
                    begin
                        gap_next = gap_inc;
                        if (gap_inc == thr.gap_ticks)
                        begin
                            event_next = EV_SHORT;
                            state_next = ST_RELEASED;
                        end
                    end
                end
                ST_SECOND:
                begin
                    if (pin_high)
                        state_next = ST_BOUNCE;
                    else
                    begin
                        second_next = second_inc;
                        if (second_inc == thr.second_ticks)
                        begin
                            hold_next  = '0;
                            event_next = EV_LONG;
                            state_next = ST_LONG;
                        end
                    end
                end
                ST_LONG:
                begin
                    event_next = EV_NONE;
                    if (pin_high)
                        state_next = ST_BOUNCE;
                end
                default:
                begin
                end
            endcase
            if (state_next != state_reg)
                origin_next = state_reg;
        end
        if (rd_clr)
            event_next = EV_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_RELEASED;
            origin_reg <= ST_RELEASED;
            event_reg  <= EV_NONE;
            hold_reg   <= '0;
            gap_reg    <= '0;
            second_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            origin_reg <= origin_next;
            event_reg  <= event_next;
            hold_reg   <= hold_next;
            gap_reg    <= gap_next;
            second_reg <= second_next;
        end
    end

    assign latch = event_reg;

`ifndef SYNTHESIS
    a_event_state: assert property (@(posedge clk) disable iff (!rst_n)
        (event_reg != EV_NONE) |-> (state_reg == ST_RELEASED || state_reg == ST_LONG))
        else $error("kped_lane: event held outside released or long press");

    a_bounce_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BOUNCE) |-> (origin_reg != ST_BOUNCE))
        else $error("kped_lane: bounce entered from bounce");

    a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        (!scan_en) |=> $stable(state_reg) && $stable(hold_reg))
        else $error("kped_lane: key moved without a scan");
`endif

endmodule

// ===== sv/kped_merge.sv =====
// Merge stage: picks the addressed lane's event and holds results
// in an output register with a skid stage. Depends on kped_pkg.
module kped_merge
    import kped_pkg::*;
#(
    parameter int KEY_COUNT = KEY_COUNT_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  logic [IDX_W-1:0] key_index,
    input  logic [EV_W-1:0] latch [KEY_COUNT],
    output logic            full,
    kped_evt_if.source      evt
);

    logic [EV_W-1:0]  sel_ev;
    logic             out_valid_reg, out_valid_next;
    logic [EV_W-1:0]  out_ev_reg,    out_ev_next;
    logic [IDX_W-1:0] out_idx_reg,   out_idx_next;
    logic             skid_valid_reg, skid_valid_next;
    logic [EV_W-1:0]  skid_ev_reg,   skid_ev_next;
    logic [IDX_W-1:0] skid_idx_reg,  skid_idx_next;
    logic             pop;

    always_comb
    begin
        sel_ev = EV_NONE;
        for (int k = 0; k < KEY_COUNT; k++)
        begin
            if (k == int'(key_index))
                sel_ev = latch[k];
        end
    end

    assign pop = out_valid_reg && evt.ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_ev_next     = out_ev_reg;
        out_idx_next    = out_idx_reg;
        skid_valid_next = skid_valid_reg;
        skid_ev_next    = skid_ev_reg;
        skid_idx_next   = skid_idx_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_ev_next     = skid_ev_reg;
                out_idx_next    = skid_idx_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_ev_next    = sel_ev;
                out_idx_next   = key_index;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_ev_next    = sel_ev;
            skid_idx_next   = key_index;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_ev_reg   <= out_ev_next;
        out_idx_reg  <= out_idx_next;
        skid_ev_reg  <= skid_ev_next;
        skid_idx_reg <= skid_idx_next;
    end

    assign full           = skid_valid_reg;
    assign evt.valid      = out_valid_reg;
    assign evt.press_code = out_ev_reg;
    assign evt.key_echo   = out_idx_reg;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("kped_merge: skid holds an item ahead of the output");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && push) |-> 1'b0)
        else $error("kped_merge: item pushed into a full skid stage");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (push && out_valid_reg && !evt.ready) |=> skid_valid_reg)
        else $error("kped_merge: stalled item lost");
`endif

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for key_press_event_detector: directed table, then random phases.
// Depends on kped_pkg, kped_cmd_if, kped_evt_if and the detector RTL.
module tb_top;
    import kped_pkg::*;

    typedef struct packed {
        logic [EV_W-1:0]  ev;
        logic [IDX_W-1:0] key;
    } read_reply_t;

    typedef struct {
        logic             cmd;
        logic [PIN_W-1:0] pins;
        logic [IDX_W-1:0] idx;
        bit               typed;
        logic [EV_W-1:0]  ev;
    } stim_row_t;

    typedef struct {
        logic [MASK_W-1:0] mask;
        logic [CNT_W-1:0]  long_thr;
        logic [CNT_W-1:0]  gap_thr;
        logic [CNT_W-1:0]  second_thr;
        int                items;
        bit                choke;
    } phase_cfg_t;

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    kped_cmd_if cmd_ch();
    kped_evt_if evt_ch();

    key_press_event_detector DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd_ch  (cmd_ch),
        .evt_ch  (evt_ch),
        .cfg_we  (cfg_we),
        .cfg_idx (cfg_idx),
        .cfg_data(cfg_data)
    );

    // predictor state
    logic [MASK_W-1:0] en_mask;
    logic [CNT_W-1:0]  long_thr;
    logic [CNT_W-1:0]  gap_thr;
    logic [CNT_W-1:0]  second_thr;
    logic [ST_W-1:0]   key_st     [2];
    logic [ST_W-1:0]   came_from  [2];
    logic [EV_W-1:0]   latch_ev   [2];
    logic [CNT_W-1:0]  hold_cnt   [2];
    logic [CNT_W-1:0]  gap_cnt    [2];
    logic [CNT_W-1:0]  second_cnt [2];

    read_reply_t owed_replies[$];
    int  error_count = 0;
    bit  choke_req   = 0;
    int  burst_left  = 0;
    logic key_level [2];
    int   run_left  [2];

    stim_row_t directed_rows [0:24] = '{
        '{CMD_READ, 2'b11, 1'b0, 1'b1, EV_NONE},
        '{CMD_READ, 2'b11, 1'b1, 1'b1, EV_NONE},
        '{CMD_SCAN, 2'b10, 1'b0, 1'b0, EV_NONE},
        '{CMD_SCAN, 2'b10, 1'b0, 1'b0, EV_NONE},
        '{CMD_SCAN, 2'b11, 1'b0, 1'b0, EV_NONE},
        '{CMD_SCAN, 2'b11, 1'b0, 1'b0, EV_NONE},
        '{CMD_SCAN, 2'b11, 1'b0, 1'b0, EV_NONE},
        '{CMD_SCAN, 2'b11, 1'b0, 1'b0, EV_NONE},
        '{CMD_SCAN, 2'b11, 1'b0, 1'b0, EV_NONE},
        '{CMD_READ, 2'b11, 1'b0, 1'b1, EV_SHORT},
        '{CMD_READ, 2'b11, 1'b0, 1'b1, EV_NONE},
        '{CMD_SCAN, 2'b00, 1'b0, 1'b0, EV_NONE},
        '{CMD_SCAN, 2'b00, 1'b0, 1'b0, EV_NONE},
        '{CMD_SCAN, 2'b11, 1'b0, 1'b0, EV_NONE},
        '{CMD_SCAN, 2'b11, 1'b0, 1'b0, EV_NONE},
        '{CMD_SCAN, 2'b00, 1'b0, 1'b0, EV_NONE},
        '{CMD_SCAN, 2'b00, 1'b0, 1'b0, EV_NONE},
        '{CMD_SCAN, 2'b11, 1'b0, 1'b0, EV_NONE},
        '{CMD_SCAN, 2'b11, 1'b0, 1'b0, EV_NONE},
        '{CMD_READ, 2'b11, 1'b1, 1'b1, EV_DOUBLE},
        '{CMD_SCAN, 2'b11, 1'b0, 1'b0, EV_NONE},
        '{CMD_READ, 2'b11, 1'b0, 1'b1, EV_NONE},
        '{CMD_SCAN, 2'b01, 1'b0, 1'b0, EV_NONE},
        '{CMD_SCAN, 2'b11, 1'b0, 1'b0, EV_NONE},
        '{CMD_READ, 2'b11, 1'b1, 1'b1, EV_NONE}
    };

    phase_cfg_t phases [0:6] = '{
        '{2'd3, 8'd1,   8'd1,   8'd1,   200, 1'b0},
        '{2'd3, 8'd255, 8'd255, 8'd255, 400, 1'b0},
        '{2'd1, 8'd6,   8'd3,   8'd4,   150, 1'b0},
        '{2'd2, 8'd4,   8'd2,   8'd9,   150, 1'b0},
        '{2'd0, 8'd5,   8'd5,   8'd5,   60,  1'b0},
        '{2'd3, 8'd3,   8'd255, 8'd1,   200, 1'b0},
        '{2'd3, 8'd12,  8'd4,   8'd7,   250, 1'b1}
    };

    always #4 clk = ~clk;

    initial
    begin
        #8_000_000;
        $display("[key_press_event_detector] ERROR");
        $finish;
    end

    task automatic report_mismatch(string what, int got, int want);
        error_count++;
        if (error_count <= 100)
            $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
    endtask

    function automatic void step_key(int k, logic high);
        logic [ST_W-1:0] prev;
        logic [ST_W-1:0] next;
        logic [ST_W-1:0] from;
        prev = key_st[k];
        next = prev;
        from = came_from[k];
        case (prev)
            ST_RELEASED:
            begin
                latch_ev[k] = EV_NONE;
                if (!high)
                    next = ST_BOUNCE;
            end
            ST_BOUNCE:
            begin
                if (high)
                begin
                    if (from == ST_RELEASED || from == ST_LONG)
                        next = ST_RELEASED;
                    else if (from == ST_PRESSED)
                    begin
                        gap_cnt[k] = '0;
                        next = ST_WAIT;
                    end
                    else if (from == ST_SECOND)
                    begin
                        latch_ev[k] = EV_DOUBLE;
                        next = ST_RELEASED;
                    end
                end
                else
                begin
                    if (from == ST_PRESSED || from == ST_SECOND || from == ST_LONG)
                        next = from;
                    else if (from == ST_RELEASED)
                    begin
                        hold_cnt[k] = '0;
                        next = ST_PRESSED;
                    end
                    else if (from == ST_WAIT)
                    begin
                        second_cnt[k] = '0;
                        next = ST_SECOND;
                    end
                end
            end
            ST_PRESSED:
            begin
                if (high)
                    next = ST_BOUNCE;
                else
                begin
                    hold_cnt[k] = hold_cnt[k] + 1'b1;
                    if (hold_cnt[k] == long_thr)
                    begin
                        hold_cnt[k] = '0;
                        latch_ev[k] = EV_LONG;
                        next = ST_LONG;
                    end
                end
            end
            ST_WAIT:
            begin
                if (!high)
                    next = ST_BOUNCE;
                else
                begin
                    gap_cnt[k] = gap_cnt[k] + 1'b1;
                    if (gap_cnt[k] == gap_thr)
                    begin
                        latch_ev[k] = EV_SHORT;
                        next = ST_RELEASED;
                    end
                end
            end
            ST_SECOND:
            begin
                if (high)
                    next = ST_BOUNCE;
                else
                begin
                    second_cnt[k] = second_cnt[k] + 1'b1;
                    if (second_cnt[k] == second_thr)
                    begin
                        hold_cnt[k] = '0;
                        latch_ev[k] = EV_LONG;
                        next = ST_LONG;
                    end
                end
            end
            ST_LONG:
            begin
                latch_ev[k] = EV_NONE;
                if (high)
                    next = ST_BOUNCE;
            end
            default: ;
        endcase
        if (next != prev)
        begin
            came_from[k] = prev;
            key_st[k] = next;
        end
    endfunction

    function automatic void take_item(logic c, logic [PIN_W-1:0] pins,
                                      logic [IDX_W-1:0] idx, bit typed,
                                      logic [EV_W-1:0] typed_ev);
        read_reply_t r;
        if (c == CMD_SCAN)
        begin
            for (int k = 0; k < 2; k++)
                if (en_mask[k])
                    step_key(k, pins[k]);
        end
        else
        begin
            r.ev  = typed ? typed_ev : latch_ev[idx];
            r.key = idx;
            latch_ev[idx] = EV_NONE;
            owed_replies.push_back(r);
        end
    endfunction

    function automatic int pick_gap();
        int r;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    function automatic int pick_run();
        int sel;
        int t;
        int top;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return $urandom_range(1, 3);
        case ($urandom_range(0, 2))
            0: t = int'(long_thr);
            1: t = int'(gap_thr);
            default: t = int'(second_thr);
        endcase
        if (sel < 8)
        begin
            t = t + int'($urandom_range(0, 4)) - 1;
            return (t < 1) ? 1 : t;
        end
        top = int'(long_thr);
        if (int'(second_thr) > top)
            top = int'(second_thr);
        if (int'(gap_thr) > top)
            top = int'(gap_thr);
        return $urandom_range(1, top + 4);
    endfunction

    task automatic send_item(logic c, logic [PIN_W-1:0] pins, logic [IDX_W-1:0] idx,
                             bit typed, logic [EV_W-1:0] typed_ev);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.cmd        <= c;
        cmd_ch.pin_levels <= pins;
        cmd_ch.key_index  <= idx;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        take_item(c, pins, idx, typed, typed_ev);
    endtask

    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        while (owed_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            REG_ENABLE_MASK: en_mask    = data[MASK_W-1:0];
            REG_LONG_TICKS:  long_thr   = data;
            REG_GAP_TICKS:   gap_thr    = data;
            default:         second_thr = data;
        endcase
    endtask

    task automatic run_random(int n);
        logic [PIN_W-1:0] pins;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                send_item(CMD_READ, PIN_W'($urandom), IDX_W'($urandom), 1'b0, EV_NONE);
            end
            else
            begin
                for (int k = 0; k < 2; k++)
                begin
                    if (run_left[k] == 0)
                    begin
                        key_level[k] = ~key_level[k];
                        run_left[k] = pick_run();
                    end
                    run_left[k]--;
                    pins[k] = key_level[k];
                end
                if ($urandom_range(0, 99) < 8)
                    pins[$urandom_range(0, 1)] ^= 1'b1;
                send_item(CMD_SCAN, pins, IDX_W'($urandom), 1'b0, EV_NONE);
            end
        end
    endtask

    // result side: random back-pressure and checking
    initial
    begin
        int          rdy_left;
        logic        rdy_lvl;
        read_reply_t want;
        rdy_left = 0;
        rdy_lvl  = 1'b0;
        evt_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && evt_ch.valid && evt_ch.ready)
            begin
                if (owed_replies.size() == 0)
                    report_mismatch("unexpected result, key_echo",
                                    int'(evt_ch.key_echo), 0);
                else
                begin
                    want = owed_replies.pop_front();
                    if (evt_ch.press_code !== want.ev)
                        report_mismatch("press_code", int'(evt_ch.press_code),
                                        int'(want.ev));
                    if (evt_ch.key_echo !== want.key)
                        report_mismatch("key_echo", int'(evt_ch.key_echo),
                                        int'(want.key));
                end
            end
            if (choke_req)
            begin
                choke_req = 0;
                evt_ch.ready <= 1'b0;
                repeat (300) @(posedge clk);
                rdy_left = 0;
            end
            if (rdy_left == 0)
            begin
                if ($urandom_range(0, 9) < 6)
                begin
                    rdy_lvl  = 1'b1;
                    rdy_left = $urandom_range(1, 24);
                end
                else
                begin
                    rdy_lvl  = 1'b0;
                    rdy_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                            : $urandom_range(1, 3);
                end
            end
            rdy_left--;
            evt_ch.ready <= rdy_lvl;
        end
    end

    initial
    begin
        phase_cfg_t pc;
        clk = 1'b0;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_idx <= '0;
        cfg_data <= '0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.cmd <= CMD_SCAN;
        cmd_ch.pin_levels <= '1;
        cmd_ch.key_index <= '0;

        en_mask    = ENABLE_MASK_RST;
        long_thr   = LONG_TICKS_RST;
        gap_thr    = GAP_TICKS_RST;
        second_thr = SECOND_TICKS_RST;
        for (int k = 0; k < 2; k++)
        begin
            key_st[k]     = ST_RELEASED;
            came_from[k]  = ST_RELEASED;
            latch_ev[k]   = EV_NONE;
            hold_cnt[k]   = '0;
            gap_cnt[k]    = '0;
            second_cnt[k] = '0;
            key_level[k]  = 1'b0;
            run_left[k]   = 0;
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].cmd, directed_rows[i].pins, directed_rows[i].idx,
                      directed_rows[i].typed, directed_rows[i].ev);
        drain_results();

        for (int p = 0; p < 9; p++)
        begin
            if (p < 7)
                pc = phases[p];
            else
            begin
                pc.mask       = MASK_W'($urandom);
                pc.long_thr   = CNT_W'($urandom_range(1, 16));
                pc.gap_thr    = CNT_W'($urandom_range(1, 8));
                pc.second_thr = CNT_W'($urandom_range(1, 16));
                pc.items      = 100;
                pc.choke      = 1'b0;
            end
            write_reg(REG_ENABLE_MASK, CFG_DATA_W'(pc.mask));
            write_reg(REG_LONG_TICKS, pc.long_thr);
            write_reg(REG_GAP_TICKS, pc.gap_thr);
            write_reg(REG_SECOND_TICKS, pc.second_thr);
            cfg_we <= 1'b0;
            if (pc.choke)
                choke_req = 1;
            run_random(pc.items);
            drain_results();
        end

        if (error_count == 0)
            $display("[key_press_event_detector] OK");
        else
            $display("[key_press_event_detector] ERROR");
        $finish;
    end
endmodule

// ===== files.f =====
sv/kped_pkg.sv
sv/kped_cmd_if.sv
sv/kped_evt_if.sv
sv/kped_lane.sv
sv/kped_merge.sv
sv/key_press_event_detector.sv
verif/tb_top.sv
